// ----- rtl/qrs_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_pkg: shared definitions of the quadratic root solver
// Default number format, queue depth and the job class passed from the
// classifier to the solver back end.
// ---------------------------------------------------------------------------
package qrs_pkg;

    localparam int QRS_COEF_WIDTH  = 32;
    localparam int QRS_FRAC_BITS   = 16;
    localparam int QRS_QUEUE_DEPTH = 4;

    // Job class decided in the front end
    typedef enum logic [2:0] {
        K_INF,   // a, b, c all zero
        K_NONE,  // no real root
        K_LIN,   // a zero: root -c/b
        K_ONE,   // double root -b/2a
        K_TWO    // two roots through the square root
    } t_kind;

endpackage
`default_nettype wire

// ----- rtl/qrs_coef_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_coef_if: coefficient channel
// One beat carries the three signed coefficients of one equation.
// ---------------------------------------------------------------------------
interface qrs_coef_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] coef_a;
    logic signed [WIDTH-1:0] coef_b;
    logic signed [WIDTH-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface
`default_nettype wire

// ----- rtl/qrs_root_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_root_if: result channel
// One beat carries the outcome class, both roots and the clamp flag.
// ---------------------------------------------------------------------------
interface qrs_root_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              outcome;
    logic signed [WIDTH-1:0] root_first;
    logic signed [WIDTH-1:0] root_second;
    logic                    saturated;

    modport source (output valid, output outcome, output root_first, output root_second,
                    output saturated, input ready);
    modport sink   (input valid, input outcome, input root_first, input root_second,
                    input saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/qrs_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_front: coefficient intake and classifier
// Three stage pipe: magnitudes, products, discriminant and job class.
// ---------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    qrs_coef_if.sink         i_coef,
    output logic             o_push,
    output logic [5*COEF_WIDTH+8:0] o_entry,
    input  wire logic        i_full
);
    localparam int W  = COEF_WIDTH;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 2;

    logic pipe_en;

    // stage 1
    logic         r_v1, r1_na, r1_nb, r1_nc;
    logic [W-1:0] r1_ma, r1_mb, r1_mc;
    logic [W-1:0] n_ma, n_mb, n_mc;
    // stage 2
    logic          r_v2, r2_na, r2_nb, r2_nc;
    logic [W-1:0]  r2_ma, r2_mb, r2_mc;
    logic [PW-1:0] r2_bb, r2_ac;
    // stage 3
    logic                r_v3;
    logic [5*W+8:0]      r_entry;
    logic [DW-1:0]       bb_x, ac4_x, n_d;
    logic                negd;
    t_kind               n_kind;
    logic                n_neg;
    logic [W-1:0]        n_num;
    logic [W:0]          n_den;

    assign pipe_en      = !r_v3 || !i_full;
    assign i_coef.ready = pipe_en;
    assign o_push       = r_v3 && !i_full;
    assign o_entry      = r_entry;

    // two's complement magnitude; the most negative code maps to 2^(W-1)
    assign n_ma = i_coef.coef_a[W-1] ? (~i_coef.coef_a + {{(W-1){1'b0}}, 1'b1}) : i_coef.coef_a;
    assign n_mb = i_coef.coef_b[W-1] ? (~i_coef.coef_b + {{(W-1){1'b0}}, 1'b1}) : i_coef.coef_b;
    assign n_mc = i_coef.coef_c[W-1] ? (~i_coef.coef_c + {{(W-1){1'b0}}, 1'b1}) : i_coef.coef_c;

    always_comb begin
        bb_x  = DW'(r2_bb);
        ac4_x = {r2_ac, 2'b00};
        negd  = 1'b0;
        if (r2_mc == '0 || r2_na != r2_nc) begin
            n_d = bb_x + ac4_x;
        end else begin
            negd = bb_x < ac4_x;
            n_d  = bb_x - ac4_x;
        end

        if (r2_ma == '0) begin
            if (r2_mb == '0) begin
                n_kind = (r2_mc == '0) ? K_INF : K_NONE;
            end else begin
                n_kind = K_LIN;
            end
        end else if (negd) begin
            n_kind = K_NONE;
        end else if (n_d == '0) begin
            n_kind = K_ONE;
        end else begin
            n_kind = K_TWO;
        end

        if (r2_ma == '0) begin
            n_neg = (!r2_nc) != r2_nb;
            n_num = r2_mc;
            n_den = {1'b0, r2_mb};
        end else begin
            n_neg = (!r2_nb) != r2_na;
            n_num = r2_mb;
            n_den = {r2_ma, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (pipe_en) begin
            r_v1 <= i_coef.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_na   <= i_coef.coef_a[W-1];
            r1_nb   <= i_coef.coef_b[W-1];
            r1_nc   <= i_coef.coef_c[W-1];
            r1_ma   <= n_ma;
            r1_mb   <= n_mb;
            r1_mc   <= n_mc;
            r2_na   <= r1_na;
            r2_nb   <= r1_nb;
            r2_nc   <= r1_nc;
            r2_ma   <= r1_ma;
            r2_mb   <= r1_mb;
            r2_mc   <= r1_mc;
            r2_bb   <= PW'(r1_mb) * PW'(r1_mb);
            r2_ac   <= PW'(r1_ma) * PW'(r1_mc);
            r_entry <= {n_kind, n_neg, r2_na, r2_nb, r2_mb, n_num, n_den, n_d};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qrs_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_queue: job queue between classifier and solver
// Small circular buffer, first in first out.
// ---------------------------------------------------------------------------
module qrs_queue
    import qrs_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QRS_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qrs_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrs_back: solver back end
// Bit serial square root and one shared restoring divider, result register.
// ---------------------------------------------------------------------------
module qrs_back
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [5*COEF_WIDTH+8:0] i_entry,
    input  wire logic               i_empty,
    output logic                    o_pop,
    qrs_root_if.source              o_root
);
    localparam int W    = COEF_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = 2 * W + 2;   // discriminant
    localparam int SW   = W + 1;       // square root
    localparam int SRW  = W + 4;       // root remainder
    localparam int NMW  = W + 2;       // numerator magnitude
    localparam int NW   = NMW + F;     // scaled numerator / quotient
    localparam int DENW = W + 1;
    localparam int RW   = W + 2;       // divide remainder
    localparam int CW   = $clog2(NW + 1);

    localparam logic [1:0] OUT_INF  = 2'd0;
    localparam logic [1:0] OUT_NONE = 2'd1;
    localparam logic [1:0] OUT_ONE  = 2'd2;
    localparam logic [1:0] OUT_TWO  = 2'd3;

    typedef enum logic [2:0] {S_IDLE, S_SQRT, S_PREP, S_DIV, S_DONE} t_state;

    // queue entry fields
    logic [2:0]      e_kind_bits;
    t_kind           e_kind;
    logic            e_neg, e_na, e_nb;
    logic [W-1:0]    e_mb, e_num;
    logic [DENW-1:0] e_den;
    logic [DW-1:0]   e_d;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_outc;
    logic            r_two, r_second, r_na, r_nb, r_sat;
    logic [W-1:0]    r_mb, r_root1, r_root2;
    logic [DENW-1:0] r_den;
    logic [DW-1:0]   r_sq_d;
    logic [SRW-1:0]  r_sq_rem;
    logic [SW-1:0]   r_sq_root;
    logic [NW-1:0]   r_dv_num, r_dv_q;
    logic [RW-1:0]   r_dv_rem;
    logic            r_dv_neg, r_n2_neg;
    logic [NMW-1:0]  r_n2_mag;

    logic            r_o_valid, r_o_sat;
    logic [1:0]      r_o_outc;
    logic [W-1:0]    r_o_r1, r_o_r2;

    logic [SRW-1:0]  sq_rem_sh, sq_trial;
    logic            sq_ge;
    logic [W+2:0]    mb_ext, mbv, n1, n2, n1_abs, n2_abs;
    logic            n1_neg, n2_neg;
    logic [RW-1:0]   dv_rem_sh, dv_den;
    logic            dv_ge, dv_sat;
    logic [W-1:0]    dv_lim, dv_val, dv_root;

    assign {e_kind_bits, e_neg, e_na, e_nb, e_mb, e_num, e_den, e_d} = i_entry;
    assign e_kind = t_kind'(e_kind_bits);

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign o_root.valid       = r_o_valid;
    assign o_root.outcome     = r_o_outc;
    assign o_root.root_first  = r_o_r1;
    assign o_root.root_second = r_o_r2;
    assign o_root.saturated   = r_o_sat;

    always_comb begin
        // one result bit per step of the square root
        sq_rem_sh = {r_sq_rem[SRW-3:0], r_sq_d[DW-1:DW-2]};
        sq_trial  = {1'b0, r_sq_root, 2'b01};
        sq_ge     = sq_rem_sh >= sq_trial;

        // -b + s and -b - s, signed
        mb_ext = {3'b000, r_mb};
        mbv    = r_nb ? mb_ext : (~mb_ext + {{(W+2){1'b0}}, 1'b1});
        n1     = mbv + {2'b00, r_sq_root};
        n2     = mbv - {2'b00, r_sq_root};
        n1_abs = n1[W+2] ? (~n1 + {{(W+2){1'b0}}, 1'b1}) : n1;
        n2_abs = n2[W+2] ? (~n2 + {{(W+2){1'b0}}, 1'b1}) : n2;
        n1_neg = n1[W+2] != r_na;
        n2_neg = n2[W+2] != r_na;

        // restoring divide step
        dv_rem_sh = {r_dv_rem[RW-2:0], r_dv_num[NW-1]};
        dv_den    = {1'b0, r_den};
        dv_ge     = dv_rem_sh >= dv_den;

        // clamp and sign
        dv_lim  = r_dv_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        dv_sat  = r_dv_q > NW'(dv_lim);
        dv_val  = dv_sat ? dv_lim : r_dv_q[W-1:0];
        dv_root = r_dv_neg ? (~dv_val + {{(W-1){1'b0}}, 1'b1}) : dv_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_root.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_na     <= e_na;
                        r_nb     <= e_nb;
                        r_mb     <= e_mb;
                        r_den    <= e_den;
                        r_root1  <= '0;
                        r_root2  <= '0;
                        r_sat    <= 1'b0;
                        r_two    <= 1'b0;
                        r_second <= 1'b0;
                        unique case (e_kind)
                            K_INF: begin
                                r_outc  <= OUT_INF;
                                r_state <= S_DONE;
                            end
                            K_NONE: begin
                                r_outc  <= OUT_NONE;
                                r_state <= S_DONE;
                            end
                            K_LIN, K_ONE: begin
                                r_outc   <= OUT_ONE;
                                r_dv_num <= {2'b00, e_num, {F{1'b0}}};
                                r_dv_rem <= '0;
                                r_dv_q   <= '0;
                                r_dv_neg <= e_neg;
                                r_cnt    <= CW'(NW);
                                r_state  <= S_DIV;
                            end
                            K_TWO: begin
                                r_outc    <= OUT_TWO;
                                r_two     <= 1'b1;
                                r_sq_d    <= e_d;
                                r_sq_rem  <= '0;
                                r_sq_root <= '0;
                                r_cnt     <= CW'(SW);
                                r_state   <= S_SQRT;
                            end
                            default: begin
                                r_outc  <= OUT_NONE;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SQRT: begin
                    if (r_cnt != '0) begin
                        r_sq_d    <= {r_sq_d[DW-3:0], 2'b00};
                        r_sq_root <= {r_sq_root[SW-2:0], sq_ge};
                        r_sq_rem  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
                        r_cnt     <= r_cnt - CW'(1);
                    end else begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_dv_num <= {n1_abs[NMW-1:0], {F{1'b0}}};
                    r_dv_rem <= '0;
                    r_dv_q   <= '0;
                    r_dv_neg <= n1_neg;
                    r_n2_neg <= n2_neg;
                    r_n2_mag <= n2_abs[NMW-1:0];
                    r_cnt    <= CW'(NW);
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_dv_num <= {r_dv_num[NW-2:0], 1'b0};
                        r_dv_q   <= {r_dv_q[NW-2:0], dv_ge};
                        r_dv_rem <= dv_ge ? (dv_rem_sh - dv_den) : dv_rem_sh;
                        r_cnt    <= r_cnt - CW'(1);
                    end else begin
                        r_sat <= r_sat | dv_sat;
                        if (r_two && !r_second) begin
                            // first root done, reuse the divider for the second
                            r_root1  <= dv_root;
                            r_second <= 1'b1;
                            r_dv_num <= {r_n2_mag, {F{1'b0}}};
                            r_dv_rem <= '0;
                            r_dv_q   <= '0;
                            r_dv_neg <= r_n2_neg;
                            r_cnt    <= CW'(NW);
                        end else begin
                            if (r_second) begin
                                r_root2 <= dv_root;
                            end else begin
                                r_root1 <= dv_root;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || o_root.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_outc  <= r_outc;
                        r_o_r1    <= r_root1;
                        r_o_r2    <= r_root2;
                        r_o_sat   <= r_sat;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/quadratic_root_solver_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// quadratic_root_solver_core: real roots of a*x^2 + b*x + c = 0
// Fixed point solver with a pipelined classifier and a serial back end.
// ---------------------------------------------------------------------------
// Each beat on i_coef carries signed coefficients a, b, c in Q(W-F).F format
// (default Q16.16) and yields one beat on o_root. Outcome: 0 infinitely many
// solutions, 1 none, 2 one root (-c/b when a is zero, else -b/2a), 3 two roots
// (-b + s)/2a and (-b - s)/2a with s = floor(sqrt(b*b - 4ac)) taken from the
// exact discriminant. Roots are truncated toward zero, roots not present read
// zero, and a root outside the signed range clamps and raises saturated.
// The front end is a three stage pipe (magnitudes, products, discriminant and
// class) that takes a beat every cycle while the job queue has room; the queue
// holds QRS_QUEUE_DEPTH jobs. The back end solves one job at a time: outcomes
// 0 and 1 go straight to the result register, a single root takes one
// division (one restoring divider step per cycle), and two roots take
// COEF_WIDTH+1 square root steps plus two divisions. That divider and root
// loop set the sustained rate. A finished result waits in the output
// register while the next job runs.
// ---------------------------------------------------------------------------
module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qrs_coef_if.sink   i_coef,
    qrs_root_if.source o_root
);
    localparam int ENTRY_W = 5 * COEF_WIDTH + 9;

    logic               push, full, pop, empty;
    logic [ENTRY_W-1:0] wr_entry, rd_entry;

    qrs_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (i_coef),
        .o_push  (push),
        .o_entry (wr_entry),
        .i_full  (full)
    );

    qrs_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QRS_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (wr_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (rd_entry),
        .o_empty (empty)
    );

    qrs_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (rd_entry),
        .i_empty (empty),
        .o_pop   (pop),
        .o_root  (o_root)
    );

endmodule
`default_nettype wire

// ----- bench/qrs_checker.sv -----
// ---------------------------------------------------------------------------
// qrs_checker: root predictor and scoreboard for the quadratic solver
// Watches the coefficient and root channels, predicts each result from the
// accepted coefficients and compares it field by field in order.
// ---------------------------------------------------------------------------
module qrs_checker #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  logic [W-1:0]     i_c,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [1:0]       i_outcome,
    input  logic [W-1:0]     i_root_first,
    input  logic [W-1:0]     i_root_second,
    input  logic             i_saturated,
    output int               o_errors,
    output int               o_pending,
    output int               o_results,
    output int               o_two_roots,
    output int               o_sat_seen
);
    localparam logic [1:0] OUT_INF = 2'd0;
    localparam logic [1:0] OUT_NONE = 2'd1;
    localparam logic [1:0] OUT_ONE = 2'd2;
    localparam logic [1:0] OUT_TWO = 2'd3;

    typedef struct packed {
        logic [1:0]   outcome;
        logic [W-1:0] r1;
        logic [W-1:0] r2;
        logic         sat;
    } roots_t;

    roots_t expected_roots[$];

    // truncated, clamped quotient; sign applied after magnitude division
    function automatic logic [W-1:0] scaled_quot(input logic neg, input logic [127:0] mag,
                                                 input logic [127:0] den, inout logic sat);
        logic [127:0] q;
        logic [127:0] lim;
        q = (mag << F) / den;
        lim = neg ? (128'd1 << (W-1)) : ((128'd1 << (W-1)) - 1);
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? W'(-q) : W'(q);
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] d);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= d) r = t;
        end
        return r;
    endfunction

    function automatic roots_t solve_quadratic(input logic [W-1:0] a, input logic [W-1:0] b,
                                               input logic [W-1:0] c);
        roots_t res;
        logic signed [129:0] sa, sb, sc, disc, s, num;
        logic [127:0] den;
        logic sat;
        sat = 0;
        res = '0;
        sa = 130'($signed(a));
        sb = 130'($signed(b));
        sc = 130'($signed(c));
        if (sa == 0) begin
            if (sb == 0) begin
                res.outcome = (sc == 0) ? OUT_INF : OUT_NONE;
            end else begin
                res.outcome = OUT_ONE;
                num = -sc;
                res.r1 = scaled_quot((num < 0) != (sb < 0), 128'(num < 0 ? -num : num),
                                     128'(sb < 0 ? -sb : sb), sat);
            end
        end else begin
            disc = sb * sb - 4 * sa * sc;
            den = 128'(sa < 0 ? -2 * sa : 2 * sa);
            if (disc < 0) begin
                res.outcome = OUT_NONE;
            end else if (disc == 0) begin
                res.outcome = OUT_ONE;
                num = -sb;
                res.r1 = scaled_quot((num < 0) != (sa < 0), 128'(num < 0 ? -num : num),
                                     den, sat);
            end else begin
                res.outcome = OUT_TWO;
                s = 130'(isqrt(128'(disc)));
                num = -sb + s;
                res.r1 = scaled_quot((num < 0) != (sa < 0), 128'(num < 0 ? -num : num),
                                     den, sat);
                num = -sb - s;
                res.r2 = scaled_quot((num < 0) != (sa < 0), 128'(num < 0 ? -num : num),
                                     den, sat);
            end
        end
        res.sat = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_two_roots = 0;
        o_sat_seen = 0;
    end

    assign o_pending = expected_roots.size();

    always @(posedge i_clk) begin
        roots_t want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                expected_roots.push_back(solve_quadratic(i_a, i_b, i_c));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (i_outcome == OUT_TWO) o_two_roots++;
                if (i_saturated) o_sat_seen++;
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected beat", W'(i_outcome), '0);
                end else begin
                    want = expected_roots.pop_front();
                    if (i_outcome !== want.outcome)
                        report_mismatch("outcome", W'(i_outcome), W'(want.outcome));
                    if (i_root_first !== want.r1)
                        report_mismatch("root_first", i_root_first, want.r1);
                    if (i_root_second !== want.r2)
                        report_mismatch("root_second", i_root_second, want.r2);
                    if (i_saturated !== want.sat)
                        report_mismatch("saturated", W'(i_saturated), W'(want.sat));
                end
            end
        end
    end
endmodule

// ----- bench/tb_quadratic_root_solver_core.sv -----
// ---------------------------------------------------------------------------
// tb_quadratic_root_solver_core: top of the quadratic solver bench
// Drives directed and random coefficient beats under several idle/stall
// phases; a checker module predicts and compares every result beat.
// ---------------------------------------------------------------------------
module tb_quadratic_root_solver_core;
    import qrs_pkg::*;

    localparam int W = QRS_COEF_WIDTH;
    localparam int F = QRS_FRAC_BITS;
    localparam int RANDOM_BEATS = 1230;
    // limit sized for two-root jobs, the slowest kind, with stalls and gaps on top
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [W-1:0] ONE = 32'h0001_0000;
    localparam logic [W-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [W-1:0] MINV = 32'h8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   src_idle_pct = 0;   // sender idle percentage of the current phase
    int   snk_stall_pct = 0;  // receiver stall percentage of the current phase
    int   errors, pending, results, two_roots, sat_seen;

    qrs_coef_if #(.WIDTH(W)) coef_ch ();
    qrs_root_if #(.WIDTH(W)) root_ch ();

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    quadratic_root_solver_core #(.COEF_WIDTH(W), .FRAC_BITS(F)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_ch.sink),
        .o_root  (root_ch.source)
    );

    qrs_checker #(.W(W), .F(F)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (coef_ch.valid),
        .i_in_ready    (coef_ch.ready),
        .i_a           (coef_ch.coef_a),
        .i_b           (coef_ch.coef_b),
        .i_c           (coef_ch.coef_c),
        .i_out_valid   (root_ch.valid),
        .i_out_ready   (root_ch.ready),
        .i_outcome     (root_ch.outcome),
        .i_root_first  (root_ch.root_first),
        .i_root_second (root_ch.root_second),
        .i_saturated   (root_ch.saturated),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results),
        .o_two_roots   (two_roots),
        .o_sat_seen    (sat_seen)
    );

    initial begin
        coef_ch.valid = 1'b0;
        coef_ch.coef_a = '0;
        coef_ch.coef_b = '0;
        coef_ch.coef_c = '0;
        root_ch.ready = 1'b0;
    end

    // receiver: ready redrawn every edge from the phase's stall rate
    always @(posedge i_clk) begin
        root_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
            $display("quadratic_root_solver_core test failed");
            $finish;
        end
    end

    // one coefficient beat; holds valid until the handshake, with random gaps before it
    task automatic send_coefs(input logic [W-1:0] a, input logic [W-1:0] b,
                              input logic [W-1:0] c);
        while ($urandom_range(99) < src_idle_pct) begin
            coef_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        coef_ch.valid <= 1'b1;
        coef_ch.coef_a <= a;
        coef_ch.coef_b <= b;
        coef_ch.coef_c <= c;
        @(posedge i_clk);
        while (!coef_ch.ready) @(posedge i_clk);
    endtask

    // mostly small coefficients so that real roots are common; some full range
    function automatic logic [W-1:0] rand_coef(input int mode);
        logic [W-1:0] v;
        case (mode)
            0: v = $urandom();
            1: v = W'($signed($urandom_range(16'hffff, 0)) - 32'sh8000) << $urandom_range(16);
            2: v = '0;
            default: v = W'($signed($urandom_range(64, 0)) - 32) << 16;
        endcase
        return v;
    endfunction

    initial begin
        logic [W-1:0] a, b, c;
        int phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: linear forms, extremes, each discriminant sign
        send_coefs('0, '0, '0);                       // infinitely many
        send_coefs('0, '0, ONE);                      // no solution
        send_coefs('0, MINV, '0);                     // linear root zero (no negative zero)
        send_coefs('0, 32'h0000_0001, MAXV);          // tiny b: clamps low
        send_coefs('0, 32'h0000_0001, MINV);          // clamps positive
        send_coefs('0, 32'hffff_ffff, MAXV);          // clamps high
        send_coefs('0, 2 * ONE, -4 * ONE);            // root 2
        send_coefs(ONE, '0, ONE);                     // negative discriminant
        send_coefs(ONE, -2 * ONE, ONE);               // double root 1
        send_coefs(ONE, '0, -ONE);                    // roots +-1
        send_coefs(ONE, -3 * ONE, 2 * ONE);           // roots 2, 1
        send_coefs(MAXV, MAXV, MAXV);
        send_coefs(MINV, MINV, MINV);
        send_coefs(MINV, MAXV, MAXV);
        send_coefs(32'h0000_0001, MAXV, '0);          // tiny a: saturates
        send_coefs(32'h0000_0001, MINV, MINV);
        send_coefs(MAXV, '0, '0);                     // zero double root
        send_coefs(-ONE, ONE, '0);
        send_coefs(ONE, 32'h0000_0003, '0);           // small s: roots zero and -b/a
        send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_coefs(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        send_coefs(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);

        // random beats across idle/stall phases, including a no-idle stretch
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            phase = (n * 5) / RANDOM_BEATS;
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
                3: begin src_idle_pct = 25; snk_stall_pct = 25; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            a = rand_coef($urandom_range(9) == 0 ? 2 : $urandom_range(3));
            b = rand_coef($urandom_range(3));
            c = rand_coef($urandom_range(3));
            // exact discriminant now and then: c zero gives D = b*b, roots 0 and -b/a
            if ($urandom_range(9) == 0) begin
                a = W'($signed($urandom_range(15, 1))) << 16;
                b = W'(2 * $signed($urandom_range(15, 0)) - 15) << 16;
                c = '0;
            end
            send_coefs(a, b, c);
        end
        coef_ch.valid <= 1'b0;
        snk_stall_pct = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d result beats, %0d with two roots, %0d clamped",
                 results, two_roots, sat_seen);
        $display("phases: no idling, sender idle 65%%, receiver stall 65%%, both 25%%");
        if (errors == 0) begin
            $display("quadratic_root_solver_core test passed");
        end else begin
            $display("quadratic_root_solver_core test failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/qrs_pkg.sv
rtl/qrs_coef_if.sv
rtl/qrs_root_if.sv
rtl/qrs_front.sv
rtl/qrs_queue.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver_core.sv
bench/qrs_checker.sv
bench/tb_quadratic_root_solver_core.sv
